/* hw/rtl/ppa_pkg.sv */
`default_nettype none
package ppa_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ATAN_ENTRIES      = 32;

  // cordic datapath widths: x/y carry 8 fraction bits plus headroom for two gains
  localparam int XW = 46;
  localparam int ZW = 34;
  localparam int MW = 40;

  localparam logic [31:0] KINV = 32'd2608131496;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic        [31:0] mag_a;
    logic signed [31:0] phase_a;
    logic        [31:0] mag_b;
    logic signed [31:0] phase_b;
  } op_t;

  typedef struct packed {
    logic        [31:0] mag_out;
    logic signed [31:0] phase_out;
    logic        [1:0]  status;
  } res_t;

  function automatic int pipe_latency(input int stages);
    int n;
    n = (stages > ATAN_ENTRIES) ? ATAN_ENTRIES : stages;
    return 2 * n + 11;
  endfunction

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ppa_addsub.sv */
`default_nettype none
module ppa_addsub #(
  parameter int CORDIC_STAGES = ppa_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  ppa_pkg::op_t  op,
  output ppa_pkg::res_t res
);
  import ppa_pkg::*;

  localparam int N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam logic [26:0] RECIP45 = 27'd95443718;

  // front end, one lane per operand
  logic [15:0] a_h   [2];
  logic [15:0] a_lo  [2];
  logic [7:0]  a_k   [2];
  logic [55:0] a_mk1 [2];
  logic [39:0] a_mk2 [2];
  logic [24:0] b_q   [2];
  logic [MW-1:0] b_m [2];
  logic [18:0] c_c   [2];
  logic [24:0] c_q   [2];
  logic [MW-1:0] c_m [2];
  logic [18:0] d_c   [2];
  logic [5:0]  d_d   [2];
  logic [MW-1:0] d_m [2];
  logic [31:0] e_ang [2];
  logic [MW-1:0] e_m [2];

  logic signed [XW-1:0] rx [2][N+1];
  logic signed [XW-1:0] ry [2][N+1];
  logic signed [ZW-1:0] rz [2][N+1];

  // subtract flag rides alongside the front end and rotation stages
  logic [N+5:0] sp;

  always_ff @(posedge clk) begin
    if (en) begin
      sp <= {sp[N+4:0], op.cmd == CMD_SUB};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0] mg;
    logic [31:0] pz;
    logic [15:0] hh;
    logic [31:0] kp;
    logic [16:0] k360;
    logic [15:0] rd;
    logic [8:0]  rr;
    logic [8:0]  r2;
    logic [51:0] cq;
    logic [24:0] c45;
    logic [24:0] dd;
    logic [18:0] dv;
    logic [45:0] dq;
    logic [31:0] sh;
    logic [1:0]  qd;
    logic [31:0] zr;
    logic signed [XW-1:0] mx;

    assign mg   = (l == 0) ? op.mag_a : op.mag_b;
    assign pz   = (l == 0) ? op.phase_a : op.phase_b;
    // offset by 2^31 so the phase is unsigned; 2^31 mod 360 deg is 8 deg
    assign hh   = {~pz[31], pz[30:16]};
    assign kp   = hh * 16'd46604;
    assign k360 = a_k[l] * 9'd360;
    assign rd   = a_h[l] - k360[15:0];
    assign rr   = rd[8:0];
    assign r2   = (rr < 9'd8) ? rr + 9'd352 : rr - 9'd8;
    assign cq   = b_q[l] * RECIP45;
    assign c45  = c_c[l] * 6'd45;
    assign dd   = c_q[l] - c45;
    // (q * 65536 + 180) / 360 split as q = 45 c + d
    assign dv   = {d_d[l], 13'd0} + 19'd22;
    assign dq   = dv * RECIP45;
    assign sh   = e_ang[l] + 32'h2000_0000;
    assign qd   = sh[31:30];
    assign zr   = e_ang[l] - {qd, 30'd0};
    assign mx   = signed'({{(XW-MW){1'b0}}, e_m[l]});

    always_ff @(posedge clk) begin
      if (en) begin
        a_h[l]   <= hh;
        a_lo[l]  <= pz[15:0];
        a_k[l]   <= kp[31:24];
        a_mk1[l] <= mg[31:8] * KINV;
        a_mk2[l] <= mg[7:0] * KINV;
        b_q[l]   <= {r2, a_lo[l]};
        b_m[l]   <= MW'((a_mk1[l] + 56'(a_mk2[l] >> 8)) >> 16);
        c_c[l]   <= cq[50:32];
        c_q[l]   <= b_q[l];
        c_m[l]   <= b_m[l];
        d_c[l]   <= c_c[l];
        d_d[l]   <= dd[5:0];
        d_m[l]   <= c_m[l];
        e_ang[l] <= {d_c[l], dq[44:32]};
        e_m[l]   <= d_m[l];
        rz[l][0] <= {{(ZW-32){zr[31]}}, zr};
        unique case (qd)
          2'd0: begin rx[l][0] <= mx;  ry[l][0] <= '0;  end
          2'd1: begin rx[l][0] <= '0;  ry[l][0] <= mx;  end
          2'd2: begin rx[l][0] <= -mx; ry[l][0] <= '0;  end
          default: begin rx[l][0] <= '0; ry[l][0] <= -mx; end
        endcase
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [ZW-1:0] at;
      assign dx = ry[l][i] >>> i;
      assign dy = rx[l][i] >>> i;
      assign at = signed'(ZW'(atan_val(i)));
      always_ff @(posedge clk) begin
        if (en) begin
          if (rz[l][i] >= 0) begin
            rx[l][i+1] <= rx[l][i] - dx;
            ry[l][i+1] <= ry[l][i] + dy;
            rz[l][i+1] <= rz[l][i] - at;
          end else begin
            rx[l][i+1] <= rx[l][i] + dx;
            ry[l][i+1] <= ry[l][i] - dy;
            rz[l][i+1] <= rz[l][i] + at;
          end
        end
      end
    end
  end

  // combine, then vectoring back to polar
  logic signed [XW-1:0] gx;
  logic signed [XW-1:0] gy;
  logic signed [XW-1:0] vx [N+1];
  logic signed [XW-1:0] vy [N+1];
  logic signed [ZW-1:0] vz [N+1];
  logic [N:0] vzf;

  always_ff @(posedge clk) begin
    if (en) begin
      gx <= sp[N+5] ? rx[0][N] - rx[1][N] : rx[0][N] + rx[1][N];
      gy <= sp[N+5] ? ry[0][N] - ry[1][N] : ry[0][N] + ry[1][N];
      vzf[0] <= (gx == '0) && (gy == '0);
      if (gx < 0) begin
        vx[0] <= -gx;
        vy[0] <= -gy;
        vz[0] <= signed'(ZW'(33'h0_8000_0000));
      end else begin
        vx[0] <= gx;
        vy[0] <= gy;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] at;
    assign dx = vy[i] >>> i;
    assign dy = vx[i] >>> i;
    assign at = signed'(ZW'(atan_val(i)));
    always_ff @(posedge clk) begin
      if (en) begin
        vzf[i+1] <= vzf[i];
        if (vy[i] >= 0) begin
          vx[i+1] <= vx[i] + dx;
          vy[i+1] <= vy[i] - dy;
          vz[i+1] <= vz[i] + at;
        end else begin
          vx[i+1] <= vx[i] - dx;
          vy[i+1] <= vy[i] + dy;
          vz[i+1] <= vz[i] - at;
        end
      end
    end
  end

  // gain compensation, degree conversion, saturation
  logic [XW-1:0]  xc;
  logic [XW+15:0] i_mk1;
  logic [47:0]    i_mk2;
  logic [31:0]    i_ang;
  logic           i_zero;
  logic [XW+15:0] s1;
  logic [XW-1:0]  s2;
  logic signed [41:0] sa;
  logic [XW-9:0]  j_mag;
  logic signed [41:0] j_t;
  logic           j_zero;
  logic signed [41:0] ts;

  assign xc = vx[N][XW-1] ? '0 : vx[N];
  assign s1 = i_mk1 + (XW+16)'(i_mk2 >> 16);
  assign s2 = s1[XW+15:16] + XW'(128);
  assign sa = 42'(signed'(i_ang));
  assign ts = j_t >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      i_mk1  <= xc[XW-1:16] * KINV;
      i_mk2  <= xc[15:0] * KINV;
      i_ang  <= vz[N][31:0];
      i_zero <= vzf[N];
      j_mag  <= s2[XW-1:8];
      j_t    <= sa * 42'sd360 + 42'sd32768;
      j_zero <= i_zero;
      if (j_zero) begin
        res.mag_out   <= '0;
        res.phase_out <= '0;
        res.status    <= ST_OK;
      end else begin
        res.phase_out <= ts[31:0];
        if (j_mag > (XW-8)'(33'h0_FFFF_FFFF)) begin
          res.mag_out <= 32'hFFFF_FFFF;
          res.status  <= ST_SAT;
        end else begin
          res.mag_out <= j_mag[31:0];
          res.status  <= ST_OK;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ppa_muldiv.sv */
`default_nettype none
module ppa_muldiv #(
  parameter int CORDIC_STAGES = ppa_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  ppa_pkg::op_t  op,
  output ppa_pkg::res_t res
);
  import ppa_pkg::*;

  localparam int LAT = pipe_latency(CORDIC_STAGES);
  localparam int DS  = 16;
  localparam int PAD = LAT - DS - 1;

  typedef struct packed {
    logic               isd;
    logic               dz;
    logic               ovf;
    logic               phs;
    logic signed [31:0] ph;
    logic [63:0]        prod;
  } side_t;

  logic [48:0] num;
  logic        is_div;
  logic signed [32:0] ps;
  logic        ps_ovf;

  assign num    = {op.mag_a, 16'd0} + 49'(op.mag_b[31:1]);
  assign is_div = op.cmd == CMD_DIV;
  assign ps     = is_div ? 33'(op.phase_a) - 33'(op.phase_b)
                         : 33'(op.phase_a) + 33'(op.phase_b);
  assign ps_ovf = ps[32] != ps[31];

  side_t       sd  [DS+1];
  logic [32:0] rem [DS+1];
  logic [31:0] lo  [DS+1];
  logic [31:0] qt  [DS+1];
  logic [31:0] mbv [DS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].isd  <= is_div;
      sd[0].dz   <= op.mag_b == '0;
      // quotient cannot fit 32 bits when the top of the numerator reaches the divisor
      sd[0].ovf  <= {15'd0, num[48:32]} >= op.mag_b;
      sd[0].phs  <= ps_ovf;
      sd[0].ph   <= ps_ovf ? (ps[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : ps[31:0];
      sd[0].prod <= op.mag_a * op.mag_b;
      rem[0]     <= {16'd0, num[48:32]};
      lo[0]      <= num[31:0];
      qt[0]      <= '0;
      mbv[0]     <= op.mag_b;
    end
  end

  // restoring divider, two quotient bits per stage
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [32:0] r1;
    logic [32:0] r1s;
    logic [32:0] r2;
    logic [32:0] r2s;
    logic        b1;
    logic        b2;
    assign r1  = {rem[k][31:0], lo[k][31]};
    assign b1  = r1 >= {1'b0, mbv[k]};
    assign r1s = b1 ? r1 - {1'b0, mbv[k]} : r1;
    assign r2  = {r1s[31:0], lo[k][30]};
    assign b2  = r2 >= {1'b0, mbv[k]};
    assign r2s = b2 ? r2 - {1'b0, mbv[k]} : r2;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= r2s;
        lo[k+1]  <= {lo[k][29:0], 2'b00};
        qt[k+1]  <= {qt[k][29:0], b1, b2};
        mbv[k+1] <= mbv[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  logic [64:0] rm;
  res_t        pd [PAD];

  assign rm = {1'b0, sd[DS].prod} + 65'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0].phase_out <= sd[DS].ph;
      if (sd[DS].isd) begin
        if (sd[DS].dz) begin
          pd[0].mag_out <= 32'hFFFF_FFFF;
          pd[0].status  <= ST_DIV0;
        end else if (sd[DS].ovf) begin
          pd[0].mag_out <= 32'hFFFF_FFFF;
          pd[0].status  <= ST_SAT;
        end else begin
          pd[0].mag_out <= qt[DS];
          pd[0].status  <= sd[DS].phs ? ST_SAT : ST_OK;
        end
      end else if (|rm[64:48]) begin
        pd[0].mag_out <= 32'hFFFF_FFFF;
        pd[0].status  <= ST_SAT;
      end else begin
        pd[0].mag_out <= rm[47:16];
        pd[0].status  <= sd[DS].phs ? ST_SAT : ST_OK;
      end
    end
  end

  // match the add/subtract latency
  for (genvar j = 1; j < PAD; j++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        pd[j] <= pd[j-1];
      end
    end
  end

  assign res = pd[PAD-1];

endmodule
`default_nettype wire

/* hw/rtl/polar_phasor_alu.sv */
`default_nettype none
// channel  signals                      payload
// op       op_valid, op_stall, op       cmd, mag_a, phase_a, mag_b, phase_b
// res      res_valid, res_stall, res    mag_out, phase_out, status
//
// one beat per cycle in, one per cycle out while res_stall is low; latency is
// set by the rotation and vectoring cordic chains in series
// divide runs a 16 stage radix-4 divider, multiply rides alongside it, both padded to the same latency
// rst clears only the valid bits; the datapath holds no reset
// res_stall with a beat waiting freezes every stage and raises op_stall
module polar_phasor_alu #(
  parameter int CORDIC_STAGES = ppa_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_stall,
  input  ppa_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_stall,
  output ppa_pkg::res_t res
);
  import ppa_pkg::*;

  localparam int LAT = pipe_latency(CORDIC_STAGES);

  logic         en;
  logic [LAT-1:0] pv;
  logic [LAT-1:0] psel;
  res_t         as_res;
  res_t         md_res;

  assign en       = !(res_valid && res_stall);
  assign op_stall = !en;

  ppa_addsub #(.CORDIC_STAGES(CORDIC_STAGES)) u_addsub (
    .clk (clk),
    .en  (en),
    .op  (op),
    .res (as_res)
  );

  ppa_muldiv #(.CORDIC_STAGES(CORDIC_STAGES)) u_muldiv (
    .clk (clk),
    .en  (en),
    .op  (op),
    .res (md_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      pv        <= {pv[LAT-2:0], op_valid};
      res_valid <= pv[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      psel <= {psel[LAT-2:0], (op.cmd == CMD_MUL) || (op.cmd == CMD_DIV)};
      res  <= psel[LAT-1] ? md_res : as_res;
    end
  end

`ifndef ASSERT_OFF
  a_div0_mag: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_DIV0) |-> res.mag_out == 32'hFFFF_FFFF)
    else $error("divide by zero without saturated magnitude");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_SAT) |->
      (res.mag_out == 32'hFFFF_FFFF) || (res.phase_out == 32'sh7FFF_FFFF) ||
      (res.phase_out == 32'sh8000_0000))
    else $error("saturated status without a clamped field");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(pv) && $stable(psel))
    else $error("pipeline moved while output stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == ST_OK) || (res.status == ST_DIV0) ||
      (res.status == ST_SAT))
    else $error("unknown status code");
`endif

endmodule
`default_nettype wire
